>>> rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

	localparam int unsigned ENTRIES_DEF   = 8192;
	localparam int unsigned WORD_BITS_DEF = 32;

	localparam int unsigned IDX_W    = 13;
	localparam int unsigned LIM_W    = 14;
	localparam int unsigned STATUS_W = 2;

	localparam logic [LIM_W-1:0] MAX_ENTRIES_RST = LIM_W'(8192);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} bba_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} bba_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_WR
	} bba_state_t;

	typedef struct packed {
		bba_cmd_t         command;
		logic [IDX_W-1:0] entry_index;
	} bba_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_index;
		bba_status_t      status;
	} bba_result_t;

endpackage

`default_nettype wire

>>> rtl/bitmap_block_allocator.sv
// First-fit bitmap allocator. The bitmap sits in one RAM of WORD_BITS-wide
// words (WORD_BITS a power of two) and is walked by one word-check unit under
// a small sequencer, so busy stays high while an item is worked on. After
// reset the block is busy while it clears the RAM one word a cycle;
// configuration writes are taken meanwhile. An allocate stays busy while it
// checks words, at most ceil(limit/WORD_BITS) of them; a free splits its
// index into word and bit by a shift and a mask, then passes through a read
// state and a write state. The next item is taken only once busy is low. A
// free outside the limit, or an allocate with a limit of zero, is answered
// without going busy. Each result appears on result, marked by done for
// exactly one cycle, in the first cycle with busy low after the item; the
// receiver cannot stall, so there is no way to hold it.
`default_nettype none

module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int unsigned ENTRIES   = ENTRIES_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bba_item_t        item,
	output logic                  done,
	output bba_result_t           result,
	input  wire logic             cfg_we,
	input  wire logic [LIM_W-1:0] cfg_wdata
);

	localparam int unsigned NWORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int unsigned BW     = $clog2(WORD_BITS);
	localparam int unsigned CW0    = $clog2(ENTRIES + WORD_BITS + 1);
	localparam int unsigned CW     = (CW0 > LIM_W + 1) ? CW0 : LIM_W + 1;

	localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
	localparam logic [CW-1:0] WB_C      = CW'(WORD_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	bba_state_t        state_q, state_d;
	logic [LIM_W-1:0]  max_entries_q;
	logic [AW-1:0]     chk_word_q;
	logic [CW-1:0]     chk_base_q;
	logic              done_q;
	bba_result_t       result_q;

	logic [CW-1:0]        lim;
	logic [CW-1:0]        max_ext;
	logic [CW-1:0]        idx_ext;
	logic [CW-1:0]        remaining;
	logic [CW-1:0]        next_base;
	logic                 last_word;
	logic                 accept;
	logic                 found;
	logic [BW-1:0]        pos;
	logic [CW-1:0]        hit_index;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && !busy;

	assign max_ext   = CW'(max_entries_q);
	assign lim       = (max_ext > ENTRIES_C) ? ENTRIES_C : max_ext;
	assign idx_ext   = CW'(item.entry_index);
	assign remaining = lim - chk_base_q;
	assign next_base = chk_base_q + WB_C;
	assign last_word = (next_base >= lim) || (chk_word_q == LAST_WORD);
	assign hit_index = chk_base_q + CW'(pos);

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bba_scan #(
		.WORD_BITS(WORD_BITS),
		.CNT_W    (CW),
		.POS_W    (BW)
	) u_scan (
		.word     (ram_rdata),
		.remaining(remaining),
		.found    (found),
		.pos      (pos)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (chk_word_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (item.command == CMD_ALLOC) begin
						state_d = (lim == '0) ? ST_IDLE : ST_SCAN;
					end else begin
						state_d = (idx_ext >= lim) ? ST_IDLE : ST_FREE_RD;
					end
				end
			end
			ST_SCAN: begin
				if (found || last_word) begin
					state_d = ST_IDLE;
				end
			end
			ST_FREE_RD: state_d = ST_FREE_WR;
			ST_FREE_WR: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_word_q;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_SCAN: begin
				// prefetch the next word while this one is checked
				ram_raddr = last_word ? chk_word_q : chk_word_q + AW'(1);
				ram_we    = found;
				ram_wdata = ram_rdata | (WORD_BITS'(1) << pos);
			end
			ST_FREE_RD: begin
				ram_raddr = chk_word_q;
			end
			ST_FREE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(WORD_BITS'(1) << chk_base_q[BW-1:0]);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			max_entries_q <= MAX_ENTRIES_RST;
			chk_word_q    <= '0;
			chk_base_q    <= '0;
			done_q        <= 1'b0;
			result_q      <= '{result_index: '0, status: STATUS_OK};
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				max_entries_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					chk_word_q <= chk_word_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						if (item.command == CMD_ALLOC) begin
							chk_word_q <= '0;
							chk_base_q <= '0;
							if (lim == '0) begin
								done_q   <= 1'b1;
								result_q <= '{result_index: '0, status: STATUS_FULL};
							end
						end else begin
							// word number from the upper bits, bit from the low bits
							chk_word_q            <= AW'(idx_ext >> BW);
							chk_base_q            <= idx_ext;
							result_q.result_index <= item.entry_index;
							if (idx_ext >= lim) begin
								done_q          <= 1'b1;
								result_q.status <= STATUS_RANGE;
							end
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						done_q   <= 1'b1;
						result_q <= '{result_index: hit_index[IDX_W-1:0], status: STATUS_OK};
					end else if (last_word) begin
						done_q   <= 1'b1;
						result_q <= '{result_index: '0, status: STATUS_FULL};
					end else begin
						chk_word_q <= chk_word_q + AW'(1);
						chk_base_q <= next_base;
					end
				end
				ST_FREE_WR: begin
					done_q          <= 1'b1;
					result_q.status <= STATUS_OK;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/bba_ram.sv
`default_nettype none

module bba_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/bba_scan.sv
`default_nettype none

// Lowest clear bit of one bitmap word that still lies below the limit.
module bba_scan #(
	parameter int unsigned WORD_BITS = 32,
	parameter int unsigned CNT_W     = 15,
	parameter int unsigned POS_W     = $clog2(WORD_BITS)
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [CNT_W-1:0]     remaining,
	output logic                      found,
	output logic      [POS_W-1:0]     pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!word[b] && (CNT_W'(b) < remaining)) begin
				found = 1'b1;
				pos   = POS_W'(b);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bba_checker.sv
`default_nettype none

module bba_checker
	import bba_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire bba_item_t        item,
	input wire logic             done,
	input wire bba_result_t      result
);

	logic accept;

	assign accept = start && !busy;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without an item");

	a_free_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command == CMD_FREE) |=>
			(busy && !done) ||
			(done && result.status == STATUS_RANGE &&
			 result.result_index == $past(item.entry_index)))
		else $error("free item neither started nor rejected with echo");

	a_alloc_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command == CMD_ALLOC) |=>
			(busy && !done) ||
			(done && result.status == STATUS_FULL && result.result_index == '0))
		else $error("allocate item neither started nor reported full");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
